@@ rtl/swmn_pkg.sv @@
// Shared constants and types for the sliding-window min/max normalizer.
`timescale 1ns / 1ps
package swmn_pkg;
  localparam int unsigned WindowSizeDefault = 256;
  localparam int unsigned ResampleDefault   = 4;
  localparam int unsigned SampleW           = 16;
  localparam int unsigned LevelW            = 8;

  // Per-channel extreme values, minimum and maximum.
  typedef struct packed {
    logic [SampleW-1:0] min_v;
    logic [SampleW-1:0] max_v;
  } ext_t;
endpackage

@@ rtl/swmn_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module swmn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/swmn_lane.sv @@
// One channel lane: window store, extreme tracking and rescan compare.
`timescale 1ns / 1ps
module swmn_lane #(
  parameter int unsigned WINDOW_SIZE = swmn_pkg::WindowSizeDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           we,
  input  logic [$clog2(WINDOW_SIZE)-1:0] addr,
  input  logic [swmn_pkg::SampleW-1:0]   wdata,
  output logic [swmn_pkg::SampleW-1:0]   rdata,
  input  logic                           clr,      // restart extremes
  input  logic                           take,     // fold value at slot
  input  logic [swmn_pkg::SampleW-1:0]   take_v,
  input  logic [$clog2(WINDOW_SIZE)-1:0] take_slot,
  output swmn_pkg::ext_t                 ext,
  output logic [$clog2(WINDOW_SIZE)-1:0] min_pos,
  output logic [$clog2(WINDOW_SIZE)-1:0] max_pos
);
  localparam int unsigned AW = $clog2(WINDOW_SIZE);

  swmn_pkg::ext_t ext_r;
  logic [AW-1:0]  min_pos_r, max_pos_r;

  swmn_ram #(.WIDTH(swmn_pkg::SampleW), .DEPTH(WINDOW_SIZE)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      ext_r.min_v <= '1;
      ext_r.max_v <= '0;
      min_pos_r   <= '0;
      max_pos_r   <= '0;
    end else if (take) begin
      if (take_v <= ext_r.min_v) begin
        ext_r.min_v <= take_v;
        min_pos_r   <= take_slot;
      end
      if (take_v >= ext_r.max_v) begin
        ext_r.max_v <= take_v;
        max_pos_r   <= take_slot;
      end
    end
  end

  assign ext     = ext_r;
  assign min_pos = min_pos_r;
  assign max_pos = max_pos_r;
endmodule

@@ rtl/swmn_scale.sv @@
// Serial scaler: (mid - min) * 255 / (max - min), one quotient bit a cycle.
`timescale 1ns / 1ps
module swmn_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [swmn_pkg::SampleW-1:0] mid,
  input  swmn_pkg::ext_t               ext,
  output logic                         done,
  output logic [swmn_pkg::LevelW-1:0]  level,
  output logic                         flat
);
  localparam int unsigned SW = swmn_pkg::SampleW;
  localparam int unsigned NW = SW + swmn_pkg::LevelW;   // numerator width

  logic [NW-1:0]              num_r;
  logic [SW:0]                rem_r;
  logic [SW-1:0]              span_r;
  logic [$clog2(NW+1)-1:0]    cnt_r;
  logic                       busy_r, done_r, flat_r;
  logic [SW:0]                rem_sh;
  logic [SW-1:0]              off;

  always_comb begin
    off = '0;
    if (ext.max_v > ext.min_v && mid > ext.min_v) begin
      off = mid - ext.min_v;
      if (off > ext.max_v - ext.min_v) off = ext.max_v - ext.min_v;
    end
    rem_sh = {rem_r[SW-1:0], num_r[NW-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        flat_r <= ext.max_v <= ext.min_v;
        span_r <= ext.max_v - ext.min_v;
        num_r  <= ({{swmn_pkg::LevelW{1'b0}}, off} << swmn_pkg::LevelW)
                  - {{swmn_pkg::LevelW{1'b0}}, off};
        rem_r  <= '0;
        cnt_r  <= ($clog2(NW+1))'(NW);
      end else if (busy_r) begin
        if (rem_sh >= {1'b0, span_r}) begin
          rem_r <= rem_sh - {1'b0, span_r};
          num_r <= {num_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          num_r <= {num_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign flat  = flat_r;
  assign level = flat_r ? '0 : num_r[swmn_pkg::LevelW-1:0];
endmodule

@@ rtl/sliding_window_minmax_normalizer.sv @@
// Top level of the sliding-window min/max normalizer.
`timescale 1ns / 1ps
// Takes one ECG/PPG sample pair per transaction into two WINDOW_SIZE-entry
// windows, one lane per channel, each tracking its window min and max. An
// item passes through IDLE and WRITE normally; when the overwritten slot held
// a tracked extreme the lanes rescan the window from oldest to newest through
// the single RAM port per lane. Every RESAMPLE-th sample once the window is
// full yields the middle sample of each channel scaled to 0..255 after the
// middle read and the shared-timing serial dividers; the output load waits
// while the output register is still held by the receiver. A new pair is
// accepted only in IDLE, after the previous one is through. No clearing pass.
module sliding_window_minmax_normalizer #(
  parameter int unsigned WINDOW_SIZE = swmn_pkg::WindowSizeDefault,
  parameter int unsigned RESAMPLE    = swmn_pkg::ResampleDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] ecg_sample, [31:16] ppg_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] ecg_level, [15:8] ppg_level,
                                  // [16] ecg_flat, [17] ppg_flat, rest zero
);
  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam int unsigned PW = (RESAMPLE > 1) ? $clog2(RESAMPLE) : 1;
  localparam logic [AW-1:0] HalfW = AW'(WINDOW_SIZE / 2);
  localparam logic [AW-1:0] UpperW = AW'(WINDOW_SIZE - WINDOW_SIZE / 2);
  localparam logic [AW-1:0] LastSlot = AW'(WINDOW_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_SCAN, S_SCAN_LAST, S_MIDRD, S_DIV, S_OUT
  } state_t;

  state_t        state_r;
  logic [AW-1:0] wp_r, slot_r, addr_r, scan_slot_r;
  logic [AW:0]   scan_cnt_r;
  logic          full_r, was_full_r;
  logic [PW-1:0] phase_r;
  logic [15:0]   ecg_in_r, ppg_in_r;
  logic          we, clr, take, start;
  logic [AW-1:0] addr, take_slot;
  logic [15:0]   ecg_rd, ppg_rd, ecg_tv, ppg_tv;
  swmn_pkg::ext_t ecg_ext, ppg_ext;
  logic [AW-1:0] e_mn, e_mx, p_mn, p_mx;
  logic          e_done, p_done, e_flat, p_flat;
  logic [7:0]    e_lvl, p_lvl;
  logic          hit, emit;
  logic [PW-1:0] phase_nxt;
  logic [AW-1:0] mid_slot;
  logic [23:0]   out_r;
  logic          out_v_r;

  assign hit = (e_mn == slot_r) || (e_mx == slot_r) || (p_mn == slot_r) || (p_mx == slot_r);
  assign phase_nxt = (RESAMPLE > 1 && phase_r == PW'(RESAMPLE - 1)) ? '0
                     : (RESAMPLE > 1 ? phase_r + 1'b1 : '0);
  assign emit = was_full_r && (phase_r == '0);
  // middle of the window, counted back from the next write slot
  assign mid_slot = (wp_r >= HalfW) ? wp_r - HalfW : wp_r + UpperW;

  always_comb begin
    we = 1'b0; clr = 1'b0; take = 1'b0; start = 1'b0;
    addr = addr_r; take_slot = slot_r;
    ecg_tv = ecg_in_r; ppg_tv = ppg_in_r;
    unique case (state_r)
      S_WRITE: begin
        we = 1'b1; addr = slot_r;
        if (was_full_r && hit) begin
          clr = 1'b1;
          addr = slot_r;
        end else begin
          take = 1'b1;
        end
      end
      S_SCAN: begin
        take = (scan_cnt_r != '0);
        take_slot = scan_slot_r;
        ecg_tv = ecg_rd; ppg_tv = ppg_rd;
      end
      S_MIDRD: start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      full_r  <= 1'b0;
      phase_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ecg_in_r   <= in_tdata[15:0];
            ppg_in_r   <= in_tdata[31:16];
            slot_r     <= wp_r;
            was_full_r <= full_r;
            wp_r       <= (wp_r == LastSlot) ? '0 : wp_r + 1'b1;
            if (wp_r == LastSlot) full_r <= 1'b1;
            phase_r    <= phase_nxt;
            state_r    <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (was_full_r && hit) begin
            // rescan from oldest (wp) to newest
            addr_r      <= wp_r;
            scan_cnt_r  <= '0;
            state_r     <= S_SCAN;
          end else if (emit) begin
            addr_r  <= mid_slot;
            state_r <= S_MIDRD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SCAN: begin
          // read issued at addr_r; data valid next cycle
          scan_slot_r <= addr_r;
          addr_r      <= (addr_r == LastSlot) ? '0 : addr_r + 1'b1;
          scan_cnt_r  <= scan_cnt_r + 1'b1;
          if (scan_cnt_r == (AW+1)'(WINDOW_SIZE)) state_r <= S_SCAN_LAST;
        end
        S_SCAN_LAST: begin
          if (emit) begin
            addr_r  <= mid_slot;
            state_r <= S_MIDRD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_MIDRD: state_r <= S_DIV;
        S_DIV: begin
          if (e_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_v_r) begin
            out_r   <= {6'd0, p_flat, e_flat, p_lvl, e_lvl};
            out_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  swmn_lane #(.WINDOW_SIZE(WINDOW_SIZE)) u_ecg (
    .clk(clk), .rst_n(rst_n), .we(we), .addr(addr), .wdata(ecg_in_r), .rdata(ecg_rd),
    .clr(clr), .take(take), .take_v(ecg_tv), .take_slot(take_slot),
    .ext(ecg_ext), .min_pos(e_mn), .max_pos(e_mx)
  );
  swmn_lane #(.WINDOW_SIZE(WINDOW_SIZE)) u_ppg (
    .clk(clk), .rst_n(rst_n), .we(we), .addr(addr), .wdata(ppg_in_r), .rdata(ppg_rd),
    .clr(clr), .take(take), .take_v(ppg_tv), .take_slot(take_slot),
    .ext(ppg_ext), .min_pos(p_mn), .max_pos(p_mx)
  );

  // merge: both dividers run in lockstep; MIDRD read data arrives at start
  logic start_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) start_d_r <= 1'b0;
    else        start_d_r <= start;
  end

  swmn_scale u_ecg_div (
    .clk(clk), .rst_n(rst_n), .start(start_d_r), .mid(ecg_rd), .ext(ecg_ext),
    .done(e_done), .level(e_lvl), .flat(e_flat)
  );
  swmn_scale u_ppg_div (
    .clk(clk), .rst_n(rst_n), .start(start_d_r), .mid(ppg_rd), .ext(ppg_ext),
    .done(p_done), .level(p_lvl), .flat(p_flat)
  );

  logic unused_done;
  assign unused_done = p_done;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;
endmodule

@@ bench/sliding_window_minmax_normalizer_tb.sv @@
// Testbench for the sliding-window min/max normalizer: stream stimulus, scoreboard, checks.
`timescale 1ns / 1ps
module sliding_window_minmax_normalizer_tb;

  localparam int unsigned WIN = swmn_pkg::WindowSizeDefault;
  localparam int unsigned RSMP = swmn_pkg::ResampleDefault;
  localparam int unsigned MAX_CYCLES = 2_000_000;

  typedef struct packed {
    logic [swmn_pkg::LevelW-1:0] ecg_level;
    logic [swmn_pkg::LevelW-1:0] ppg_level;
    logic                        ecg_flat;
    logic                        ppg_flat;
  } level_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] ecg_sample, [31:16] ppg_sample
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [7:0] ecg_level, [15:8] ppg_level, [16] ecg_flat, [17] ppg_flat

  sliding_window_minmax_normalizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state
  logic [swmn_pkg::SampleW-1:0] ecg_win [WIN];
  logic [swmn_pkg::SampleW-1:0] ppg_win [WIN];
  int unsigned wr_slot;
  bit          win_full;
  int unsigned phase;
  logic [swmn_pkg::SampleW-1:0] ecg_lo, ecg_hi, ppg_lo, ppg_hi;
  int unsigned pos_ecg_lo, pos_ecg_hi, pos_ppg_lo, pos_ppg_hi;

  level_t expected_levels[$];
  int     error_count;
  int     sent_count;
  int     cycle_count;
  bit     hold_off;
  bit     rand_stall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("%0t timeout", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void clear_extremes();
    ecg_lo = '1; ecg_hi = '0; ppg_lo = '1; ppg_hi = '0;
    pos_ecg_lo = 0; pos_ecg_hi = 0; pos_ppg_lo = 0; pos_ppg_hi = 0;
  endfunction

  function automatic void track_slot(int unsigned s);
    if (ecg_win[s] <= ecg_lo) begin ecg_lo = ecg_win[s]; pos_ecg_lo = s; end
    if (ecg_win[s] >= ecg_hi) begin ecg_hi = ecg_win[s]; pos_ecg_hi = s; end
    if (ppg_win[s] <= ppg_lo) begin ppg_lo = ppg_win[s]; pos_ppg_lo = s; end
    if (ppg_win[s] >= ppg_hi) begin ppg_hi = ppg_win[s]; pos_ppg_hi = s; end
  endfunction

  function automatic logic [swmn_pkg::LevelW-1:0] scale_level(
      logic [swmn_pkg::SampleW-1:0] mid, logic [swmn_pkg::SampleW-1:0] lo,
      logic [swmn_pkg::SampleW-1:0] hi, output logic flat);
    int unsigned span, off;
    if (hi <= lo) begin
      flat = 1'b1;
      return '0;
    end
    flat = 1'b0;
    span = hi - lo;
    off = (mid > lo) ? mid - lo : 0;
    if (off > span) off = span;
    return swmn_pkg::LevelW'(off * 255 / span);
  endfunction

  function automatic void predict_levels(logic [swmn_pkg::SampleW-1:0] e,
                                         logic [swmn_pkg::SampleW-1:0] p);
    bit was_full;
    int unsigned s, mid;
    level_t r;
    was_full = win_full;
    s = wr_slot;
    ecg_win[s] = e;
    ppg_win[s] = p;
    wr_slot = (s + 1) % WIN;
    if (wr_slot == 0) win_full = 1'b1;
    if (was_full && (pos_ecg_lo == s || pos_ecg_hi == s || pos_ppg_lo == s ||
                     pos_ppg_hi == s)) begin
      clear_extremes();
      for (int unsigned k = 0; k < WIN; k++) track_slot((wr_slot + k) % WIN);
    end else begin
      track_slot(s);
    end
    phase = (phase + 1) % RSMP;
    if (!was_full || phase != 0) return;
    mid = (wr_slot + WIN - WIN / 2) % WIN;
    r.ecg_level = scale_level(ecg_win[mid], ecg_lo, ecg_hi, r.ecg_flat);
    r.ppg_level = scale_level(ppg_win[mid], ppg_lo, ppg_hi, r.ppg_flat);
    expected_levels.push_back(r);
  endfunction

  // tvalid stays high between back-to-back transactions; dropped only for a gap
  task automatic send_sample(logic [swmn_pkg::SampleW-1:0] e,
                             logic [swmn_pkg::SampleW-1:0] p, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p, e};
    do @(posedge clk); while (!in_tready);
    predict_levels(e, p);
    sent_count++;
  endtask

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (rand_stall && out_tready && out_tvalid) begin
        stall = $urandom_range(0, 11);
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    level_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tdata[15:8], out_tdata[16], out_tdata[17]};
      if (expected_levels.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, out_tdata);
        error_count++;
      end else begin
        exp_r = expected_levels.pop_front();
        if (got.ecg_level !== exp_r.ecg_level)
          $display("%0t ecg_level expected %0d actual %0d", $time, exp_r.ecg_level,
                   got.ecg_level);
        if (got.ppg_level !== exp_r.ppg_level)
          $display("%0t ppg_level expected %0d actual %0d", $time, exp_r.ppg_level,
                   got.ppg_level);
        if (got.ecg_flat !== exp_r.ecg_flat)
          $display("%0t ecg_flat expected %0d actual %0d", $time, exp_r.ecg_flat,
                   got.ecg_flat);
        if (got.ppg_flat !== exp_r.ppg_flat)
          $display("%0t ppg_flat expected %0d actual %0d", $time, exp_r.ppg_flat,
                   got.ppg_flat);
        if (out_tdata[23:18] !== '0)
          $display("%0t pad bits expected 0 actual %h", $time, out_tdata[23:18]);
        if (got !== exp_r || out_tdata[23:18] !== '0) error_count++;
      end
    end
  end

  // fill window with flat values, then extremes in directed order
  task automatic test_fill_and_extremes();
    for (int i = 0; i < WIN; i++) send_sample(16'h1234, 16'hFFFF, 1'b0);
    send_sample(16'h0000, 16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 16'h0000, 1'b1);
    send_sample(16'h8000, 16'h7FFF, 1'b1);
    send_sample(16'h1234, 16'h1234, 1'b1);
    send_sample(16'h5555, 16'hAAAA, 1'b1);
    send_sample(16'hAAAA, 16'h5555, 1'b1);
    send_sample(16'h0001, 16'hFFFE, 1'b1);
    send_sample(16'hFFFE, 16'h0001, 1'b1);
  endtask

  // random values mixing full-range, narrow-range, ramp and rail-to-rail modes, so extremes age out
  task automatic test_random_samples(int count);
    logic [swmn_pkg::SampleW-1:0] e, p;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: begin e = 16'($urandom); p = 16'($urandom); end
        1: begin
          e = 16'h4000 + 16'($urandom_range(0, 7));
          p = 16'hC000 - 16'($urandom_range(0, 7));
        end
        2: begin e = i[15:0] * 16'd97; p = 16'hFFFF - i[15:0] * 16'd61; end
        default: begin e = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000; p = 16'($urandom); end
      endcase
      send_sample(e, p, $urandom_range(0, 3) != 0);
    end
  endtask

  // block the receiver while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random_samples(40);
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    error_count = 0;
    sent_count = 0;
    cycle_count = 0;
    hold_off = 1'b0;
    rand_stall = 1'b0;
    wr_slot = 0;
    win_full = 1'b0;
    phase = 0;
    clear_extremes();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_and_extremes();
    rand_stall = 1'b1;
    test_random_samples(350);
    test_backpressure();
    test_random_samples(330);
    in_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (WIN + 40) @(posedge clk);
    if (error_count == 0 && expected_levels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ sliding_window_minmax_normalizer.f @@
rtl/swmn_pkg.sv
rtl/swmn_ram.sv
rtl/swmn_lane.sv
rtl/swmn_scale.sv
rtl/sliding_window_minmax_normalizer.sv
bench/sliding_window_minmax_normalizer_tb.sv
